// ===== rtl/epi_pkg.sv =====
// package for the eased point interpolator
// types, codes and constants shared by the rtl files other than epi_ram; no dependencies
`default_nettype none

package epi_pkg;

   localparam int MAX_POINTS_DEF = 64;

   localparam int COORD_W   = 32;
   localparam int PROG_W    = 17;
   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 23;
   localparam int DIV_STEPS = DIV_NUM_W;

   localparam logic [PROG_W-1:0]    ONE_Q16     = 17'h10000;
   localparam int                   RECIP_SHIFT = 32;
   localparam logic [25:0]          EASE_RECIP  = 26'd42949673;
   localparam logic [DIV_NUM_W-1:0] EASE_BIAS   = 40'd3276800;
   localparam logic [DIV_NUM_W-1:0] EASE_BASE   = 40'd386547056640;
   localparam logic [DIV_NUM_W-1:0] EASE_LIN    = 40'd1179648;

   localparam logic [19:0] DURATION_RST = 20'd196608;
   localparam logic [6:0]  COUNT_RST    = 7'd1;

   typedef enum logic [2:0] {
      KIND_LOAD    = 3'd0,
      KIND_TICK    = 3'd1,
      KIND_START   = 3'd2,
      KIND_REVERSE = 3'd3,
      KIND_RESET   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_MOVING = 2'd1,
      PH_END    = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      EASE_LINEAR = 2'd0,
      EASE_INOUT  = 2'd1,
      EASE_BOUNCE = 2'd2
   } easing_type;

   typedef enum logic [1:0] {
      REG_DURATION = 2'd0,
      REG_EASING   = 2'd1,
      REG_COUNT    = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic div_start;
      logic div_take;
      logic sq_load;
      logic ease_load;
      logic ediv_start;
      logic ediv_take;
      logic cnt_clear;
      logic cnt_inc;
      logic mul_load;
      logic out_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic tick_go;
      logic div_done;
      logic ease_div;
      logic n_zero;
      logic last;
      logic out_taken;
   } ctrl_status_type;

endpackage

`default_nettype wire

// ===== rtl/epi_if.sv =====
// request and response channel interfaces of the eased point interpolator
// depends on epi_pkg
`default_nettype none

interface epi_req_if import epi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [2:0]                kind;
   logic [5:0]                point_index;
   logic signed [COORD_W-1:0] start_x;
   logic signed [COORD_W-1:0] start_y;
   logic signed [COORD_W-1:0] start_z;
   logic signed [COORD_W-1:0] dest_x;
   logic signed [COORD_W-1:0] dest_y;
   logic signed [COORD_W-1:0] dest_z;
   logic [15:0]               delta_time;

   modport source (output valid, kind, point_index, start_x, start_y, start_z,
                   dest_x, dest_y, dest_z, delta_time, input ready);
   modport sink (input valid, kind, point_index, start_x, start_y, start_z,
                 dest_x, dest_y, dest_z, delta_time, output ready);
endinterface

interface epi_rsp_if import epi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [5:0]                out_index;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic [1:0]                phase;
   logic                      last;

   modport source (output valid, out_index, pos_x, pos_y, pos_z, phase, last,
                   input ready);
   modport sink (input valid, out_index, pos_x, pos_y, pos_z, phase, last,
                 output ready);
endinterface

`default_nettype wire

// ===== rtl/eased_point_interpolator_core.sv =====
// top level of the eased point interpolator
// depends on epi_pkg, epi_if, epi_ctrl and epi_dp
//
// Animates up to MAX_POINTS stored 3-D points (Q16.16) from start to
// destination. Load, start, reverse and reset requests, and a tick outside
// the moving phase, take effect when accepted. A tick while moving runs a
// bit-serial divide for the progress step, then squaring and easing, and in
// bounce mode past 0.8 a reciprocal multiply; it then reads the point stores
// and emits one response per point, waiting for the response side to take
// each one. Requests are not taken during a tick.
`default_nettype none

module eased_point_interpolator_core import epi_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   epi_req_if.sink     req_chan,
   epi_rsp_if.source   rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [19:0] csr_wdata
);
   logic            req_ready;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign req_chan.ready = req_ready;

   epi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   epi_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_accept      (req_chan.valid && req_ready),
      .req_kind        (req_chan.kind),
      .req_point_index (req_chan.point_index),
      .req_start_x     (req_chan.start_x),
      .req_start_y     (req_chan.start_y),
      .req_start_z     (req_chan.start_z),
      .req_dest_x      (req_chan.dest_x),
      .req_dest_y      (req_chan.dest_y),
      .req_dest_z      (req_chan.dest_z),
      .req_delta_time  (req_chan.delta_time),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_out_index   (rsp_chan.out_index),
      .rsp_pos_x       (rsp_chan.pos_x),
      .rsp_pos_y       (rsp_chan.pos_y),
      .rsp_pos_z       (rsp_chan.pos_z),
      .rsp_phase       (rsp_chan.phase),
      .rsp_last        (rsp_chan.last),
      .cmd             (cmd),
      .status          (status)
   );

endmodule

`default_nettype wire

// ===== rtl/epi_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module epi_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [AW-1:0]          waddr,
   input  wire logic [WIDTH-1:0]       wdata,
   input  wire logic [AW-1:0]          raddr,
   output logic      [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/epi_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on epi_pkg
`default_nettype none

module epi_div import epi_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_NUM_W-1:0] num,
   input  wire logic [DIV_DEN_W-1:0] den,
   output logic                      done,
   output logic      [DIV_NUM_W-1:0] quot
);
   localparam int CW = $clog2(DIV_STEPS + 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CW-1:0]        cnt_ff;
   logic [DIV_NUM_W-1:0] qn_ff;
   logic [DIV_NUM_W-1:0] qn_in;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] rem_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W+1:0] diff;

   always_comb begin
      shifted = {rem_ff, qn_ff[DIV_NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b0, den_ff};
      if (!diff[DIV_DEN_W+1]) begin
         rem_in = diff[DIV_DEN_W-1:0];
         qn_in  = {qn_ff[DIV_NUM_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[DIV_DEN_W-1:0];
         qn_in  = {qn_ff[DIV_NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(DIV_STEPS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         qn_ff  <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         qn_ff  <= qn_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quot = qn_ff;

endmodule

`default_nettype wire

// ===== rtl/epi_dp.sv =====
// datapath: registers, point stores, progress, easing and blend
// depends on epi_pkg, epi_ram and epi_div
`default_nettype none

module epi_dp import epi_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic [1:0]                csr_index,
   input  wire logic [19:0]               csr_wdata,
   input  wire logic                      req_accept,
   input  wire logic [2:0]                req_kind,
   input  wire logic [5:0]                req_point_index,
   input  wire logic signed [COORD_W-1:0] req_start_x,
   input  wire logic signed [COORD_W-1:0] req_start_y,
   input  wire logic signed [COORD_W-1:0] req_start_z,
   input  wire logic signed [COORD_W-1:0] req_dest_x,
   input  wire logic signed [COORD_W-1:0] req_dest_y,
   input  wire logic signed [COORD_W-1:0] req_dest_z,
   input  wire logic [15:0]               req_delta_time,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [5:0]                     rsp_out_index,
   output logic signed [COORD_W-1:0]      rsp_pos_x,
   output logic signed [COORD_W-1:0]      rsp_pos_y,
   output logic signed [COORD_W-1:0]      rsp_pos_z,
   output logic [1:0]                     rsp_phase,
   output logic                           rsp_last,
   input  wire ctrl_cmd_type              cmd,
   output ctrl_status_type                status
);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int RW = 3 * COORD_W;
   localparam logic [6:0] MAX_CNT = 7'(MAX_POINTS);

   logic [19:0]       duration_ff;
   logic [1:0]        mode_ff;
   logic [6:0]        count_ff;
   logic              swapped_ff;
   logic [PROG_W-1:0] progress_ff;
   phase_type         phase_ff;
   logic [15:0]       dt_ff;
   logic              done_ff;
   logic              hi_ff;
   logic [33:0]       sq_ff;
   logic [PROG_W-1:0] ease_ff;
   logic [23:0]       ediv_ff;
   logic [6:0]        cnt_ff;

   logic signed [COORD_W-1:0] a_ff    [3];
   logic signed [COORD_W-1:0] d_ff    [3];
   logic signed [50:0]        prod_ff [3];

   logic                      out_valid_ff;
   logic [5:0]                out_index_ff;
   logic signed [COORD_W-1:0] out_pos_ff [3];
   logic [1:0]                out_phase_ff;
   logic                      out_last_ff;

   logic                 load_ok;
   logic                 ram_we;
   logic [RW-1:0]        start_word;
   logic [RW-1:0]        dest_word;
   logic [RW-1:0]        a_rd;
   logic [RW-1:0]        b_rd;
   logic [RW-1:0]        sb_word;
   logic [RW-1:0]        db_word;
   logic                 div_start;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] quot;
   logic [40:0]          sum;
   logic                 fin;
   logic [18:0]          p5;
   logic [PROG_W-1:0]    x;
   logic                 hi;
   logic [DIV_NUM_W-1:0] sq40;
   logic [DIV_NUM_W-1:0] m1lo;
   logic [DIV_NUM_W-1:0] m1hi;
   logic [DIV_NUM_W-1:0] m2lo;
   logic [DIV_NUM_W-1:0] ediv_num;
   logic [49:0]          recip_prod;
   logic [PROG_W-1:0]    ease_val;
   logic [6:0]           n;

   logic signed [32:0]        diff    [3];
   logic signed [50:0]        rnd     [3];
   logic signed [51:0]        sum_r   [3];
   logic signed [COORD_W-1:0] blended [3];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         duration_ff <= DURATION_RST;
         mode_ff     <= EASE_INOUT;
         count_ff    <= COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_DURATION: duration_ff <= csr_wdata;
            REG_EASING:   mode_ff     <= csr_wdata[1:0];
            REG_COUNT:    count_ff    <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // point stores
   assign load_ok    = (req_kind == KIND_LOAD) && ({1'b0, req_point_index} < MAX_CNT);
   assign ram_we     = req_accept && load_ok;
   assign start_word = {req_start_z, req_start_y, req_start_x};
   assign dest_word  = {req_dest_z, req_dest_y, req_dest_x};

   epi_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_bank_a (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_point_index[AW-1:0]),
      .wdata (swapped_ff ? dest_word : start_word),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (a_rd)
   );

   epi_ram #(.WIDTH(RW), .DEPTH(MAX_POINTS)) u_bank_b (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_point_index[AW-1:0]),
      .wdata (swapped_ff ? start_word : dest_word),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (b_rd)
   );

   assign sb_word = swapped_ff ? b_rd : a_rd;
   assign db_word = swapped_ff ? a_rd : b_rd;

   // divider for the progress step
   assign div_start = cmd.div_start;
   assign div_num   = {8'b0, dt_ff, 16'b0};
   assign div_den   = {3'b0, duration_ff};

   epi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (quot)
   );

   assign sum = 41'(progress_ff) + 41'(quot);
   assign fin = (duration_ff == 20'd0) || (sum >= 41'(ONE_Q16));

   // easing operand
   always_comb begin
      p5 = {progress_ff, 2'b0} + 19'(progress_ff);
      case (mode_ff)
         EASE_INOUT: begin
            hi = progress_ff >= 17'd32768;
            x  = hi ? 17'({ONE_Q16 - progress_ff, 1'b0}) : progress_ff;
         end
         EASE_BOUNCE: begin
            hi = p5 >= 19'd262144;
            x  = hi ? 17'(p5 - 19'd262144) : progress_ff;
         end
         default: begin
            hi = 1'b0;
            x  = progress_ff;
         end
      endcase
   end

   always_comb begin
      sq40     = 40'(sq_ff);
      m1lo     = ((sq40 << 1) + 40'd32768) >> 16;
      m1hi     = 40'(ONE_Q16) - ((sq40 + 40'd65536) >> 17);
      m2lo     = (sq40 * 40'd45 + 40'd1048576) >> 21;
      ediv_num = EASE_BASE + 40'(x) * EASE_LIN - (sq40 << 3) + EASE_BIAS;
      case (mode_ff)
         EASE_INOUT:  ease_val = hi_ff ? m1hi[PROG_W-1:0] : m1lo[PROG_W-1:0];
         EASE_BOUNCE: ease_val = m2lo[PROG_W-1:0];
         default:     ease_val = progress_ff;
      endcase
   end

   // bounce tail: divide by 100 after the shift by 16
   assign recip_prod = ediv_ff * EASE_RECIP;

   // move state
   always_ff @(posedge clock) begin
      if (reset) begin
         swapped_ff  <= 1'b0;
         progress_ff <= '0;
         phase_ff    <= PH_START;
      end else if (req_accept) begin
         case (req_kind)
            KIND_LOAD: begin
               if (load_ok) begin
                  progress_ff <= '0;
                  phase_ff    <= PH_START;
               end
            end
            KIND_START: begin
               if (phase_ff == PH_START) begin
                  progress_ff <= '0;
                  phase_ff    <= PH_MOVING;
               end
            end
            KIND_REVERSE: begin
               if (phase_ff == PH_END) begin
                  swapped_ff  <= ~swapped_ff;
                  progress_ff <= '0;
                  phase_ff    <= PH_MOVING;
               end
            end
            KIND_RESET: begin
               progress_ff <= '0;
               phase_ff    <= PH_START;
            end
            default: ;
         endcase
      end else if (cmd.div_take) begin
         progress_ff <= fin ? ONE_Q16 : sum[PROG_W-1:0];
         phase_ff    <= fin ? PH_END : PH_MOVING;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         dt_ff <= req_delta_time;
      end
      if (cmd.div_take) begin
         done_ff <= fin;
      end
      if (cmd.sq_load) begin
         sq_ff <= 34'(x) * 34'(x);
         hi_ff <= hi;
      end
      if (cmd.ediv_start) begin
         ediv_ff <= ediv_num[39:16];
      end
      if (cmd.ease_load) begin
         ease_ff <= ease_val;
      end else if (cmd.ediv_take) begin
         ease_ff <= recip_prod[RECIP_SHIFT+PROG_W-1:RECIP_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 7'd1;
      end
   end

   // blend
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]  = 33'(signed'(db_word[k*COORD_W +: COORD_W]))
                  - 33'(signed'(sb_word[k*COORD_W +: COORD_W]));
         rnd[k]   = (prod_ff[k] + 51'sd32768) >>> 16;
         sum_r[k] = 52'(a_ff[k]) + 52'(rnd[k]);
         if (sum_r[k] > 52'sd2147483647) begin
            blended[k] = 32'sh7fffffff;
         end else if (sum_r[k] < -52'sd2147483648) begin
            blended[k] = 32'sh80000000;
         end else begin
            blended[k] = sum_r[k][COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         for (int k = 0; k < 3; k++) begin
            a_ff[k]    <= sb_word[k*COORD_W +: COORD_W];
            d_ff[k]    <= db_word[k*COORD_W +: COORD_W];
            prod_ff[k] <= diff[k] * $signed({1'b0, ease_ff});
         end
      end
   end

   // response register
   assign n = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_index_ff <= cnt_ff[5:0];
         out_phase_ff <= phase_ff;
         out_last_ff  <= (cnt_ff + 7'd1) == n;
         for (int k = 0; k < 3; k++) begin
            out_pos_ff[k] <= done_ff ? d_ff[k] : blended[k];
         end
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_index = out_index_ff;
   assign rsp_pos_x     = out_pos_ff[0];
   assign rsp_pos_y     = out_pos_ff[1];
   assign rsp_pos_z     = out_pos_ff[2];
   assign rsp_phase     = out_phase_ff;
   assign rsp_last      = out_last_ff;

   assign status.tick_go   = (req_kind == KIND_TICK) && (phase_ff == PH_MOVING);
   assign status.div_done  = div_done;
   assign status.ease_div  = (mode_ff == EASE_BOUNCE) && hi_ff && !done_ff;
   assign status.n_zero    = n == 7'd0;
   assign status.last      = (cnt_ff + 7'd1) == n;
   assign status.out_taken = out_valid_ff && rsp_ready;

endmodule

`default_nettype wire

// ===== rtl/epi_ctrl.sv =====
// controller state machine sequencing a tick through the datapath
// depends on epi_pkg
`default_nettype none

module epi_ctrl import epi_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DSTART,
      ST_DIV,
      ST_SQ,
      ST_EASE,
      ST_EDIV,
      ST_RD,
      ST_MUL,
      ST_SUM,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cnt_clear = 1'b1;
               if (status.tick_go) begin
                  state_in = ST_DSTART;
               end
            end
         end
         ST_DSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               cmd.div_take = 1'b1;
               state_in     = ST_SQ;
            end
         end
         ST_SQ: begin
            cmd.sq_load = 1'b1;
            state_in    = ST_EASE;
         end
         ST_EASE: begin
            if (status.ease_div) begin
               cmd.ediv_start = 1'b1;
               state_in       = ST_EDIV;
            end else begin
               cmd.ease_load = 1'b1;
               state_in      = status.n_zero ? ST_IDLE : ST_RD;
            end
         end
         ST_EDIV: begin
            cmd.ediv_take = 1'b1;
            state_in      = status.n_zero ? ST_IDLE : ST_RD;
         end
         ST_RD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_SUM;
         end
         ST_SUM: begin
            cmd.out_load = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_taken) begin
               cmd.cnt_inc = 1'b1;
               state_in    = status.last ? ST_IDLE : ST_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire
